/* design/pmt_pkg.sv */
// Shared types, widths and codes for the pending move tracker.
package pmt_pkg;

   // Table depth default for the top level parameter
   localparam int ENTRIES_DEFAULT = 16;

   // Field widths
   localparam int KIND_W   = 1;
   localparam int DISK_W   = 8;
   localparam int FILE_W   = 24;
   localparam int AMOUNT_W = 16;
   localparam int MOVED_W  = 17;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_MOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PENDING   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // Input word
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [DISK_W-1:0]   disk;
      logic [FILE_W-1:0]   file_no;
      logic [AMOUNT_W-1:0] amount;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entries_in_use;
   } rsp_word_type;

   // Payload held by one table slot
   typedef struct packed {
      logic [DISK_W-1:0]   disk;
      logic [FILE_W-1:0]   file_no;
      logic [AMOUNT_W-1:0] written;
      logic [MOVED_W-1:0]  moved;
   } slot_type;

   // Slot as handed between neighbouring cells
   typedef struct packed {
      logic     valid;
      slot_type slot;
   } entry_type;

   // Carry walking down the chain during a lookup
   typedef struct packed {
      logic seen;   // a matching entry sits further forward
      logic rm;     // the frontmost match completes and leaves
   } chain_type;

   // Command broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_MATCH,
      CELL_SCAN,
      CELL_APPLY
   } cell_op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

/* design/pending_move_tracker_unit.sv */
// Top level of the pending move tracker: sequencer, result register and the row of cells.
//
// Keeps an ordered table of ENTRIES files waiting for their children to be moved.
// An add word shifts every entry one cell back and loads the new one at the front in the
// cycle it is accepted, unless the table is full, which is then left as is and reported;
// its result is offered on the next cycle. A move word passes through a match, a scan and
// an apply state after acceptance before its result is offered: every cell compares its
// key, the match carry walks the row one cell per cycle to find the frontmost match, and
// that entry is updated or the gap behind it closed. One word is in the block at a time,
// and a new word is taken once the previous result has been taken or is leaving.
module pending_move_tracker_unit #(
   parameter int ENTRIES = pmt_pkg::ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pmt_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pmt_pkg::rsp_word_type rsp_data
);
   import pmt_pkg::*;

   localparam int CountW = $clog2(ENTRIES + 1);
   localparam int ScanW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   state_type          state_ff, state_in;
   req_word_type       item_ff, item_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [ScanW-1:0]   scan_ff, scan_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff, rsp_data_in;
   cell_op_type        cell_op;
   logic               req_accept;
   logic               full;
   logic               scan_done;
   entry_type          new_entry;
   entry_type          entry_out [ENTRIES];
   chain_type          chain_out [ENTRIES];
   logic [ENTRIES-1:0] valid_vec;
   chain_type          tail;

   assign req_accept = req_valid && req_ready;
   assign full       = count_ff == CountW'(ENTRIES);
   assign scan_done  = scan_ff == ScanW'(ENTRIES - 1);
   assign tail       = chain_out[ENTRIES-1];

   // Entry loaded into the front cell by an add
   assign new_entry.valid        = 1'b1;
   assign new_entry.slot.disk    = req_data.disk;
   assign new_entry.slot.file_no = req_data.file_no;
   assign new_entry.slot.written = req_data.amount;
   assign new_entry.slot.moved   = '0;

   // Row of cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      chain_type chain_i;

      if (i == 0) begin : g_front
         assign prev_e  = new_entry;
         assign chain_i = '0;
      end else begin : g_inner
         assign prev_e  = entry_out[i-1];
         assign chain_i = chain_out[i-1];
      end

      if (i == ENTRIES - 1) begin : g_back
         assign next_e = '0;
      end else begin : g_mid
         assign next_e = entry_out[i+1];
      end

      pmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .item       (item_ff),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .chain_in   (chain_i),
         .entry      (entry_out[i]),
         .chain_out  (chain_out[i])
      );

      assign valid_vec[i] = entry_out[i].valid;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.kind == KIND_MOVE) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      cell_op   = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_accept && req_data.kind == KIND_ADD && !full) begin
               cell_op = CELL_INSERT;
            end
         end
         ST_MATCH: cell_op = CELL_MATCH;
         ST_SCAN:  cell_op = CELL_SCAN;
         ST_APPLY: cell_op = CELL_APPLY;
         default:  cell_op = CELL_HOLD;
      endcase
   end

   // Item hold, scan count, table count and result word
   always_comb begin
      item_in      = item_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         item_in = req_data;
      end
      if (state_ff == ST_MATCH) begin
         scan_in = '0;
      end else if (state_ff == ST_SCAN) begin
         scan_in = scan_ff + ScanW'(1);
      end
      if (req_accept && req_data.kind == KIND_ADD) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_data_in.status = STATUS_FULL;
         end else begin
            count_in           = count_ff + CountW'(1);
            rsp_data_in.status = STATUS_ADDED;
         end
         rsp_data_in.entries_in_use = COUNT_W'(count_in);
      end else if (state_ff == ST_APPLY) begin
         rsp_valid_in = 1'b1;
         if (!tail.seen) begin
            rsp_data_in.status = STATUS_NOT_FOUND;
         end else if (tail.rm) begin
            count_in           = count_ff - CountW'(1);
            rsp_data_in.status = STATUS_COMPLETE;
         end else begin
            rsp_data_in.status = STATUS_PENDING;
         end
         rsp_data_in.entries_in_use = COUNT_W'(count_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Count tracks the valid bits of the row
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count disagrees with valid cells");

   // Valid entries form a run from the front
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
      else $error("gap in valid entries");

   // The result register is free when a move finishes
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> !rsp_valid_ff)
      else $error("move result would overwrite a waiting word");

   // A completed move removes exactly one entry
   a_complete_drops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && tail.rm) |=> count_ff == $past(count_ff) - CountW'(1))
      else $error("completed move did not remove one entry");

endmodule

/* design/pmt_cell.sv */
// One slot of the tracker table: holds an entry and passes data to its neighbours.
module pmt_cell (
   input  logic                clock,
   input  logic                reset,
   input  pmt_pkg::cell_op_type op,
   input  pmt_pkg::req_word_type item,
   input  pmt_pkg::entry_type   prev_entry,
   input  pmt_pkg::entry_type   next_entry,
   input  pmt_pkg::chain_type   chain_in,
   output pmt_pkg::entry_type   entry,
   output pmt_pkg::chain_type   chain_out
);
   import pmt_pkg::*;

   logic                valid_ff, valid_in;
   slot_type            slot_ff, slot_in;
   logic                hit_ff, hit_in;
   logic                cmpl_ff, cmpl_in;
   chain_type           chain_ff, chain_ff_in;
   logic [MOVED_W-1:0]  sum;
   logic                key_eq;
   logic                winner;

   // Local compare and sum against the broadcast word
   assign key_eq = (slot_ff.disk == item.disk) && (slot_ff.file_no == item.file_no);
   assign sum    = slot_ff.moved + MOVED_W'(item.amount);
   assign winner = hit_ff && !chain_ff.seen;

   // Carry handed to the next cell
   assign chain_out.seen = chain_ff.seen | hit_ff;
   assign chain_out.rm   = chain_ff.seen ? chain_ff.rm : (hit_ff & cmpl_ff);

   assign entry.valid = valid_ff;
   assign entry.slot  = slot_ff;

   // Next state of the cell
   always_comb begin
      valid_in    = valid_ff;
      slot_in     = slot_ff;
      hit_in      = hit_ff;
      cmpl_in     = cmpl_ff;
      chain_ff_in = chain_ff;
      case (op)
         CELL_INSERT: begin
            valid_in = prev_entry.valid;
            slot_in  = prev_entry.slot;
         end
         CELL_MATCH: begin
            hit_in      = valid_ff && key_eq;
            cmpl_in     = sum >= MOVED_W'(slot_ff.written);
            chain_ff_in = '0;
         end
         CELL_SCAN: begin
            chain_ff_in = chain_in;
         end
         CELL_APPLY: begin
            // close the gap behind a completed entry, else add the amount to the frontmost match
            if (chain_out.rm) begin
               valid_in = next_entry.valid;
               slot_in  = next_entry.slot;
            end else if (winner) begin
               slot_in.moved = sum;
            end
            hit_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         cmpl_ff  <= 1'b0;
         chain_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         cmpl_ff  <= cmpl_in;
         chain_ff <= chain_ff_in;
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
